// ----- hdl/esa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types and constants of the entity slot allocator.
// ----------------------------------------------------------------------------
package esa_pkg;

    localparam int ID_W          = 64;
    localparam int SLOT_W        = 8;
    localparam int FILL_W        = 9;
    localparam int RESERVED_SLOT = 256;
    localparam int NUM_CELLS     = 255;
    localparam int SLOT_LIMIT    = (RESERVED_SLOT < 256) ? RESERVED_SLOT : 256;
    localparam int GROUP_SIZE    = 16;
    localparam int NUM_GROUPS    = (NUM_CELLS + GROUP_SIZE) / GROUP_SIZE;

    typedef enum logic [2:0] {
        ST_NULL    = 3'd0,
        ST_FOUND   = 3'd1,
        ST_NEW     = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef enum logic {
        MODE_ACQUIRE = 1'b0,
        MODE_CLEAR   = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MRG1,
        S_MRG2,
        S_DEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [FILL_W-1:0] fill;
    } cell_ctl_t;

endpackage

// ----- hdl/esa_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_cell
// One slot of the table: holds its identifier and flags a match on the key.
// ----------------------------------------------------------------------------
module esa_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [esa_pkg::SLOT_W-1:0]    slot_index,
    input  logic [esa_pkg::ID_W-1:0]      key,
    input  esa_pkg::cell_ctl_t            ctl,
    output logic                          hit
);
    import esa_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic            hit_reg;
    logic            hit_next;
    logic            in_use;

    assign in_use   = {1'b0, slot_index} < ctl.fill;
    assign hit_next = in_use && (id_reg == key);
    assign hit      = hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (ctl.wr_slot == slot_index))
        begin
            id_reg <= key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

// ----- hdl/esa_hit_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_hit_merge
// Two-stage registered merge of the cell hit flags into one slot number.
// ----------------------------------------------------------------------------
module esa_hit_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [esa_pkg::NUM_CELLS-1:0] hits,
    output logic [esa_pkg::SLOT_W-1:0]    hit_slot,
    output logic                          hit_any
);
    import esa_pkg::*;

    logic [SLOT_W-1:0] group_reg  [NUM_GROUPS];
    logic [SLOT_W-1:0] group_next [NUM_GROUPS];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // slots are unique, so at most one flag is set: an OR of masked numbers
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if ((g * GROUP_SIZE + j) < NUM_CELLS)
                begin
                    if (hits[g * GROUP_SIZE + j])
                    begin
                        group_next[g] = group_next[g] | SLOT_W'(g * GROUP_SIZE + j + 1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        slot_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            slot_next = slot_next | group_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= '0;
            end
            slot_reg <= '0;
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
            slot_reg <= slot_next;
        end
    end

    assign hit_slot = slot_reg;
    assign hit_any  = (slot_reg != '0);

endmodule

// ----- hdl/entity_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_slot_allocator
// Interns 64-bit entity identifiers into dense 8-bit owner slots.
// ----------------------------------------------------------------------------
// One word at a time. An acquire with a nonzero identifier passes through these
// states in order from the accepting edge to the result register: compare,
// where every cell of the 255-cell row compares the key in parallel, the
// registered hit merge states MRG1 and MRG2, decide and write the new slot,
// and load the result. Clear and null-identifier words go straight to the
// result load. The next word is accepted in the cycle after the result is
// loaded, even if it has not yet been taken; no new word is taken before the
// block is through with the last one. While the result register still holds
// an untaken word, the block waits in its response state and holds off the input.
module entity_slot_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [esa_pkg::ID_W-1:0]    entity_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [esa_pkg::SLOT_W-1:0]  slot,
    output logic [2:0]                  status
);
    import esa_pkg::*;

    state_t              state_reg, state_next;
    logic [ID_W-1:0]     key_reg;
    logic [FILL_W-1:0]   next_free_reg, next_free_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    status_t             out_status_reg, out_status_next;
    cell_ctl_t           cell_ctl;
    logic                wr_en;
    logic [NUM_CELLS-1:0] hits;
    logic [SLOT_W-1:0]   hit_slot;
    logic                hit_any;
    logic                in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign cell_ctl = '{wr_en: wr_en, wr_slot: next_free_reg[SLOT_W-1:0], fill: next_free_reg};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        esa_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot_index (SLOT_W'(i + 1)),
            .key        (key_reg),
            .ctl        (cell_ctl),
            .hit        (hits[i])
        );
    end

    esa_hit_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .hits     (hits),
        .hit_slot (hit_slot),
        .hit_any  (hit_any)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg <= entity_id;
        end
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= FILL_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        next_free_next  = next_free_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        next_free_next  = FILL_W'(1);
                        res_slot_next   = '0;
                        res_status_next = ST_CLEARED;
                        state_next      = S_RESP;
                    end
                    else if (entity_id == '0)
                    begin
                        res_slot_next   = '0;
                        res_status_next = ST_NULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:  state_next = S_MRG1;
            S_MRG1: state_next = S_MRG2;
            S_MRG2: state_next = S_DEC;
            S_DEC:
            begin
                if (hit_any)
                begin
                    res_slot_next   = hit_slot;
                    res_status_next = ST_FOUND;
                end
                else if ((next_free_reg >= FILL_W'(SLOT_LIMIT)) ||
                         (next_free_reg > FILL_W'(NUM_CELLS)))
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    next_free_next  = next_free_reg + FILL_W'(1);
                    res_slot_next   = next_free_reg[SLOT_W-1:0];
                    res_status_next = ST_NEW;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign slot      = out_slot_reg;
    assign status    = out_status_reg;

    a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status_reg == ST_FOUND || out_status_reg == ST_NEW) |-> slot != '0)
        else $error("found or new result carries slot zero");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg != '0 && next_free_reg <= FILL_W'(SLOT_LIMIT))
        else $error("free slot pointer out of range");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> next_free_reg < FILL_W'(SLOT_LIMIT) && !hit_any)
        else $error("slot written while full or already present");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode == MODE_CLEAR |=> next_free_reg == FILL_W'(1))
        else $error("clear did not empty the table");

endmodule
